// ===== design/mke_pkg.sv =====
package mke_pkg;

	localparam int CODE_MAX = 6;
	localparam int CNT_W    = 3;
	localparam int CHAR_W   = 8;
	localparam int UNIT_W   = 8;
	localparam int RUN_W    = 13;
	localparam int TRI_W    = UNIT_W + 2;

	localparam logic [CHAR_W-1:0] CHAR_SPACE  = 8'h20;
	localparam logic [CHAR_W-1:0] CHAR_COMMA  = 8'h2C;
	localparam logic [CHAR_W-1:0] CHAR_PERIOD = 8'h2E;

	typedef enum logic {
		REG_UNIT_LENGTH = 1'b0,
		REG_PAD_LENGTH  = 1'b1
	} reg_index_t;

	// elements left aligned, first element in the top bit, 1 = dash
	typedef struct packed {
		logic                known;
		logic [CODE_MAX-1:0] pattern;
		logic [CNT_W-1:0]    count;
	} code_t;

	typedef struct packed {
		logic                lead;
		logic [CODE_MAX-1:0] pattern;
		logic [CNT_W-1:0]    count;
		logic                space;
		logic                cgap;
		logic                tail;
		logic                fin;
	} desc_t;

	typedef enum logic [2:0] {
		RUN_NONE,
		RUN_LEAD,
		RUN_ELEM,
		RUN_EGAP,
		RUN_SPACE,
		RUN_CGAP,
		RUN_TAIL
	} run_kind_t;

	function automatic code_t code_lookup(input logic [CHAR_W-1:0] c);
		code_t r;
		r = '{known: 1'b1, pattern: '0, count: '0};
		unique case (c)
			8'h41: begin r.pattern = 6'b010000; r.count = 3'd2; end
			8'h42: begin r.pattern = 6'b100000; r.count = 3'd4; end
			8'h43: begin r.pattern = 6'b101000; r.count = 3'd4; end
			8'h44: begin r.pattern = 6'b100000; r.count = 3'd3; end
			8'h45: begin r.pattern = 6'b000000; r.count = 3'd1; end
			8'h46: begin r.pattern = 6'b001000; r.count = 3'd4; end
			8'h47: begin r.pattern = 6'b110000; r.count = 3'd3; end
			8'h48: begin r.pattern = 6'b000000; r.count = 3'd4; end
			8'h49: begin r.pattern = 6'b000000; r.count = 3'd2; end
			8'h4A: begin r.pattern = 6'b011100; r.count = 3'd4; end
			8'h4B: begin r.pattern = 6'b101000; r.count = 3'd3; end
			8'h4C: begin r.pattern = 6'b010000; r.count = 3'd4; end
			8'h4D: begin r.pattern = 6'b110000; r.count = 3'd2; end
			8'h4E: begin r.pattern = 6'b100000; r.count = 3'd2; end
			8'h4F: begin r.pattern = 6'b111000; r.count = 3'd3; end
			8'h50: begin r.pattern = 6'b011000; r.count = 3'd4; end
			8'h51: begin r.pattern = 6'b110100; r.count = 3'd4; end
			8'h52: begin r.pattern = 6'b010000; r.count = 3'd3; end
			8'h53: begin r.pattern = 6'b000000; r.count = 3'd3; end
			8'h54: begin r.pattern = 6'b100000; r.count = 3'd1; end
			8'h55: begin r.pattern = 6'b001000; r.count = 3'd3; end
			8'h56: begin r.pattern = 6'b000100; r.count = 3'd4; end
			8'h57: begin r.pattern = 6'b011000; r.count = 3'd3; end
			8'h58: begin r.pattern = 6'b100100; r.count = 3'd4; end
			8'h59: begin r.pattern = 6'b101100; r.count = 3'd4; end
			8'h5A: begin r.pattern = 6'b110000; r.count = 3'd4; end
			CHAR_COMMA: begin r.pattern = 6'b110011; r.count = 3'd6; end
			CHAR_PERIOD: begin r.pattern = 6'b010101; r.count = 3'd6; end
			default: r.known = 1'b0;
		endcase
		return r;
	endfunction

endpackage

// ===== design/mke_front.sv =====
module mke_front import mke_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	input  logic              q_full,
	input  logic [CHAR_W-1:0] character,
	input  logic              final_character,
	input  logic              pad_nonzero,
	output logic              q_push,
	output desc_t             q_desc
);

	logic  started_q;
	logic  accept;
	logic  is_space;
	logic  known;
	code_t code;

	assign accept   = push && !q_full;
	assign code     = code_lookup(character);
	assign is_space = (character == CHAR_SPACE);
	assign known    = code.known || is_space;

	always_comb begin
		q_desc.lead    = !started_q && pad_nonzero;
		q_desc.pattern = code.pattern;
		q_desc.count   = code.known ? code.count : '0;
		q_desc.space   = is_space;
		q_desc.cgap    = known && !final_character;
		q_desc.tail    = final_character && pad_nonzero;
		q_desc.fin     = final_character;
	end

	// characters that cause no run never enter the queue
	assign q_push = accept && (q_desc.lead || q_desc.count != '0 || q_desc.space ||
		q_desc.cgap || q_desc.tail);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			started_q <= 1'b0;
		end else if (accept) begin
			started_q <= !final_character;
		end
	end

endmodule

// ===== design/mke_queue.sv =====
module mke_queue import mke_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  wr,
	input  desc_t wr_desc,
	input  logic  rd,
	output desc_t rd_desc,
	output logic  full,
	output logic  q_empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int CNT_QW = $clog2(DEPTH + 1);

	desc_t             mem_q [DEPTH];
	logic [PTR_W-1:0]  wr_ptr_q;
	logic [PTR_W-1:0]  rd_ptr_q;
	logic [CNT_QW-1:0] count_q;
	logic              do_wr;
	logic              do_rd;

	assign full    = (count_q == CNT_QW'(DEPTH));
	assign q_empty = (count_q == '0);
	assign do_wr   = wr && !full;
	assign do_rd   = rd && !q_empty;
	assign rd_desc = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (do_wr) begin
			mem_q[wr_ptr_q] <= wr_desc;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (do_wr) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
			end
			if (do_rd) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
			end
			if (do_wr && !do_rd) begin
				count_q <= count_q + 1'b1;
			end else if (do_rd && !do_wr) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

endmodule

// ===== design/mke_back.sv =====
module mke_back import mke_pkg::*; (
	input  logic              clk,
	input  logic              arst_n,
	input  logic [UNIT_W-1:0] unit_length,
	input  logic [RUN_W-1:0]  pad_length,
	input  logic              q_empty,
	input  desc_t             q_desc,
	output logic              q_pop,
	input  logic              pop,
	output logic              empty,
	output logic              level,
	output logic [RUN_W-1:0]  run_length,
	output logic              item_done,
	output logic              message_done
);

	logic                lead_q;
	logic [CNT_W-1:0]    elem_left_q;
	logic                in_gap_q;
	logic [CODE_MAX-1:0] pattern_q;
	logic                space_q;
	logic                cgap_q;
	logic                tail_q;
	logic                fin_q;

	logic                lead_n;
	logic [CNT_W-1:0]    elem_left_n;
	logic                in_gap_n;
	logic [CODE_MAX-1:0] pattern_n;
	logic                space_n;
	logic                cgap_n;
	logic                tail_n;

	logic                out_valid_q;
	logic                level_q;
	logic [RUN_W-1:0]    run_length_q;
	logic                item_done_q;
	logic                message_done_q;

	run_kind_t           kind;
	logic                busy;
	logic                emit;
	logic                last;
	logic                run_level;
	logic [RUN_W-1:0]    run_len;
	logic [UNIT_W-1:0]   unit_eff;
	logic [TRI_W-1:0]    unit_tri;

	// a unit length of zero behaves as one
	assign unit_eff = (unit_length == '0) ? UNIT_W'(1) : unit_length;
	assign unit_tri = TRI_W'(unit_eff) + {1'b0, unit_eff, 1'b0};

	always_comb begin
		priority if (lead_q) begin
			kind = RUN_LEAD;
		end else if (elem_left_q != '0) begin
			kind = in_gap_q ? RUN_EGAP : RUN_ELEM;
		end else if (space_q) begin
			kind = RUN_SPACE;
		end else if (cgap_q) begin
			kind = RUN_CGAP;
		end else if (tail_q) begin
			kind = RUN_TAIL;
		end else begin
			kind = RUN_NONE;
		end
	end

	assign busy  = (kind != RUN_NONE);
	assign emit  = busy && (!out_valid_q || pop);
	assign q_pop = !busy && !q_empty;

	// pending work once the current run has gone out
	always_comb begin
		lead_n      = lead_q;
		elem_left_n = elem_left_q;
		in_gap_n    = in_gap_q;
		pattern_n   = pattern_q;
		space_n     = space_q;
		cgap_n      = cgap_q;
		tail_n      = tail_q;
		unique case (kind)
			RUN_LEAD:  lead_n = 1'b0;
			RUN_ELEM: begin
				elem_left_n = elem_left_q - 1'b1;
				in_gap_n    = (elem_left_q > CNT_W'(1));
				pattern_n   = pattern_q << 1;
			end
			RUN_EGAP:  in_gap_n = 1'b0;
			RUN_SPACE: space_n = 1'b0;
			RUN_CGAP:  cgap_n = 1'b0;
			RUN_TAIL:  tail_n = 1'b0;
			default: ;
		endcase
	end

	assign last = !(lead_n || elem_left_n != '0 || space_n || cgap_n || tail_n);

	always_comb begin
		run_level = 1'b0;
		run_len   = RUN_W'(unit_eff);
		unique case (kind)
			RUN_LEAD, RUN_TAIL: run_len = pad_length;
			RUN_ELEM: begin
				run_level = 1'b1;
				run_len   = pattern_q[CODE_MAX-1] ? RUN_W'(unit_tri) : RUN_W'(unit_eff);
			end
			RUN_CGAP: run_len = RUN_W'(unit_tri);
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lead_q      <= 1'b0;
			elem_left_q <= '0;
			in_gap_q    <= 1'b0;
			space_q     <= 1'b0;
			cgap_q      <= 1'b0;
			tail_q      <= 1'b0;
		end else if (q_pop) begin
			lead_q      <= q_desc.lead;
			elem_left_q <= q_desc.count;
			in_gap_q    <= 1'b0;
			space_q     <= q_desc.space;
			cgap_q      <= q_desc.cgap;
			tail_q      <= q_desc.tail;
		end else if (emit) begin
			lead_q      <= lead_n;
			elem_left_q <= elem_left_n;
			in_gap_q    <= in_gap_n;
			space_q     <= space_n;
			cgap_q      <= cgap_n;
			tail_q      <= tail_n;
		end
	end

	always_ff @(posedge clk) begin
		if (q_pop) begin
			pattern_q <= q_desc.pattern;
			fin_q     <= q_desc.fin;
		end else if (emit) begin
			pattern_q <= pattern_n;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (emit) begin
			out_valid_q <= 1'b1;
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			level_q        <= run_level;
			run_length_q   <= run_len;
			item_done_q    <= last;
			message_done_q <= last && fin_q;
		end
	end

	assign empty        = !out_valid_q;
	assign level        = level_q;
	assign run_length   = run_length_q;
	assign item_done    = item_done_q;
	assign message_done = message_done_q;

endmodule

// ===== design/morse_keying_encoder.sv =====
// morse on-off keying encoder
// input side is a queue: present character and final_character, raise push;
// the character is taken at a clock edge with push high and full low
// result side is a queue too: while empty is low the oldest run sits on level,
// run_length, item_done and message_done; pop high with empty low takes it
// configuration: wr_en, wr_index and wr_data write unit_length (index 0) or
// pad_length (index 1); the user must do so only while the block is idle, the
// block itself does not enforce it; a front stage looks each character up in
// the code table and queues a run descriptor; a back sequencer turns the
// descriptor into runs, one per cycle while the receiver takes them, and loads
// the next descriptor only once the last run of the one before has gone out
// characters that cause no run are dropped in the front
// a stalled receiver holds the output register; the sequencer then waits and
// the descriptor queue fills until full is raised
// reset empties both queues, sets unit_length to 1, pad_length to 0 and
// arms the leading pad for the next message
module morse_keying_encoder import mke_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              wr_en,
	input  logic              wr_index,
	input  logic [RUN_W-1:0]  wr_data,
	input  logic              push,
	output logic              full,
	input  logic [CHAR_W-1:0] character,
	input  logic              final_character,
	output logic              empty,
	input  logic              pop,
	output logic              level,
	output logic [RUN_W-1:0]  run_length,
	output logic              item_done,
	output logic              message_done
);

	logic [UNIT_W-1:0] unit_length_q;
	logic [RUN_W-1:0]  pad_length_q;
	logic              q_push;
	logic              q_pop;
	logic              q_empty;
	desc_t             wr_desc;
	desc_t             rd_desc;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			unit_length_q <= UNIT_W'(1);
			pad_length_q  <= '0;
		end else if (wr_en) begin
			unique case (reg_index_t'(wr_index))
				REG_UNIT_LENGTH: unit_length_q <= wr_data[UNIT_W-1:0];
				REG_PAD_LENGTH:  pad_length_q  <= wr_data;
			endcase
		end
	end

	mke_front u_front (
		.clk             (clk),
		.arst_n          (arst_n),
		.push            (push),
		.q_full          (full),
		.character       (character),
		.final_character (final_character),
		.pad_nonzero     (pad_length_q != '0),
		.q_push          (q_push),
		.q_desc          (wr_desc)
	);

	mke_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr      (q_push),
		.wr_desc (wr_desc),
		.rd      (q_pop),
		.rd_desc (rd_desc),
		.full    (full),
		.q_empty (q_empty)
	);

	mke_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.unit_length  (unit_length_q),
		.pad_length   (pad_length_q),
		.q_empty      (q_empty),
		.q_desc       (rd_desc),
		.q_pop        (q_pop),
		.pop          (pop),
		.empty        (empty),
		.level        (level),
		.run_length   (run_length),
		.item_done    (item_done),
		.message_done (message_done)
	);

endmodule

// ===== design/mke_checker.sv =====
module mke_checker import mke_pkg::*; (
	input logic             clk,
	input logic             arst_n,
	input logic             empty,
	input logic             pop,
	input logic             level,
	input logic [RUN_W-1:0] run_length,
	input logic             item_done,
	input logic             message_done
);

	// nothing can be waiting straight after reset
	a_empty_after_reset: assert property (@(posedge clk)
		$rose(arst_n) |-> empty)
		else $error("result waiting right after reset");

	// a run that is not taken stays put
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && !pop |=> !empty && $stable(level) && $stable(run_length) &&
		$stable(item_done) && $stable(message_done))
		else $error("waiting run changed before it was taken");

	// zero length runs are never emitted
	a_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		!empty |-> run_length != '0)
		else $error("run of zero length");

	// end of message is always also end of its character
	a_msg_item: assert property (@(posedge clk) disable iff (!arst_n)
		!empty && message_done |-> item_done)
		else $error("message end without character end");

endmodule

bind morse_keying_encoder mke_checker u_checker (.*);
